### rtl/mtq_pkg.sv
// ---------------------------------------------------------------------------
// mtq_pkg: shared types and constants for the matrix-to-quaternion pipeline
// Widths, slot codes, inter-stage structs and the output saturation helper.
// ---------------------------------------------------------------------------
package mtq_pkg;

  localparam int WORD_BITS   = 16;
  localparam int FRAC_BITS   = 14;
  localparam int SUM_W       = WORD_BITS + 3;        // trace and radicand candidates
  localparam int NUM_W       = WORD_BITS + 1;        // numerators of the divisions
  localparam int ARG_W       = WORD_BITS + 1;        // positive radicand
  localparam int RAD_W       = 2 * ARG_W;            // radicand scaled by 2^16
  localparam int SQRT_STEPS  = ARG_W;                // one root bit per stage
  localparam int ROOT_W      = SQRT_STEPS;
  localparam int REM_W       = ROOT_W + 3;
  // 2*sqrt(a) in the Q format is sqrt(a << (FRAC_BITS + 2)).
  localparam int RAD_SHIFT   = FRAC_BITS + 2;
  localparam int DIVD_W      = 32;                   // (mag << FRAC_BITS) + S/2
  localparam int DIV_Q_W     = 24;                   // quotient bits that can be nonzero
  localparam int DIV_LAT     = DIV_Q_W + 1;          // setup stage plus one stage per bit
  localparam int QRT_W       = WORD_BITS;            // (S + 2) >> 2

  localparam logic signed [SUM_W-1:0] ONE_Q = SUM_W'(1 << FRAC_BITS);
  localparam logic signed [DIV_Q_W:0] WMAX  = (DIV_Q_W+1)'((1 << (WORD_BITS - 1)) - 1);
  localparam logic signed [DIV_Q_W:0] WMIN  = -WMAX - (DIV_Q_W+1)'(1);

  typedef logic signed [WORD_BITS-1:0] word_t;

  // Which quaternion component is S/4; the other three come from divisions.
  typedef enum logic [1:0] {
    SLOT_X = 2'd0,
    SLOT_Y = 2'd1,
    SLOT_Z = 2'd2,
    SLOT_W = 2'd3
  } slot_t;

  typedef struct packed {
    word_t m00, m01, m02;
    word_t m10, m11, m12;
    word_t m20, m21, m22;
  } matrix_t;

  typedef struct packed {
    logic                    invalid;
    slot_t                   slot;
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
  } meta_t;

  typedef struct packed {
    logic              valid;
    meta_t             meta;
    logic [ARG_W-1:0]  arg;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_stage_t;

  typedef struct packed {
    logic             valid;
    logic             invalid;
    slot_t            slot;
    logic [QRT_W-1:0] quarter;
  } out_meta_t;

  function automatic word_t sat_word(input logic signed [DIV_Q_W:0] v);
    word_t r;
    if (v > WMAX) begin
      r = WMAX[WORD_BITS-1:0];
    end else if (v < WMIN) begin
      r = WMIN[WORD_BITS-1:0];
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/mtq_front.sv
// ---------------------------------------------------------------------------
// mtq_front: case selection and radicand setup
// Two stages: trace and diagonal compare, then radicand check and numerators.
// ---------------------------------------------------------------------------
module mtq_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  mtq_pkg::matrix_t    m,
  output mtq_pkg::sq_stage_t  out
);
  import mtq_pkg::*;

  logic                    s1_valid;
  logic                    s1_tpos;
  slot_t                   s1_slot;
  logic signed [SUM_W-1:0] s1_arg;
  logic signed [NUM_W-1:0] s1_d12, s1_s12, s1_d20, s1_s02, s1_d01, s1_s01;

  logic signed [SUM_W-1:0] trace, a_t, a0, a1, a2;
  logic                    k1, k2;
  word_t                   mk;

  always_comb begin
    trace = SUM_W'(m.m00) + SUM_W'(m.m11) + SUM_W'(m.m22);
    a_t   = ONE_Q + trace;
    a0    = ONE_Q + SUM_W'(m.m00) - SUM_W'(m.m11) - SUM_W'(m.m22);
    a1    = ONE_Q + SUM_W'(m.m11) - SUM_W'(m.m00) - SUM_W'(m.m22);
    a2    = ONE_Q + SUM_W'(m.m22) - SUM_W'(m.m00) - SUM_W'(m.m11);
    // Ties keep the lower diagonal index.
    k1    = m.m11 > m.m00;
    mk    = k1 ? m.m11 : m.m00;
    k2    = m.m22 > mk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_tpos <= trace > 0;
    if (trace > 0) begin
      s1_slot <= SLOT_W;
      s1_arg  <= a_t;
    end else if (k2) begin
      s1_slot <= SLOT_Z;
      s1_arg  <= a2;
    end else if (k1) begin
      s1_slot <= SLOT_Y;
      s1_arg  <= a1;
    end else begin
      s1_slot <= SLOT_X;
      s1_arg  <= a0;
    end
    s1_d12 <= NUM_W'(m.m12) - NUM_W'(m.m21);
    s1_s12 <= NUM_W'(m.m12) + NUM_W'(m.m21);
    s1_d20 <= NUM_W'(m.m20) - NUM_W'(m.m02);
    s1_s02 <= NUM_W'(m.m02) + NUM_W'(m.m20);
    s1_d01 <= NUM_W'(m.m01) - NUM_W'(m.m10);
    s1_s01 <= NUM_W'(m.m01) + NUM_W'(m.m10);
  end

  logic bad;
  meta_t meta_next;

  always_comb begin
    bad = !s1_tpos && (s1_arg <= 0);
    meta_next.invalid = bad;
    meta_next.slot    = s1_slot;
    case (s1_slot)
      SLOT_X: begin
        meta_next.n0 = s1_s01;
        meta_next.n1 = s1_s02;
        meta_next.n2 = s1_d12;
      end
      SLOT_Y: begin
        meta_next.n0 = s1_s01;
        meta_next.n1 = s1_s12;
        meta_next.n2 = s1_d20;
      end
      SLOT_Z: begin
        meta_next.n0 = s1_s02;
        meta_next.n1 = s1_s12;
        meta_next.n2 = s1_d01;
      end
      default: begin
        meta_next.n0 = s1_d12;
        meta_next.n1 = s1_d20;
        meta_next.n2 = s1_d01;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= s1_valid;
    end
    out.meta <= meta_next;
    // A bad radicand still runs through the root with a harmless value of one.
    out.arg  <= bad ? ARG_W'(1) : s1_arg[ARG_W-1:0];
    out.rem  <= '0;
    out.root <= '0;
  end

endmodule

### rtl/mtq_sqrt.sv
// ---------------------------------------------------------------------------
// mtq_sqrt: pipelined integer square root
// Computes floor(sqrt(arg * 2^16)), one result bit per register stage.
// ---------------------------------------------------------------------------
module mtq_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  mtq_pkg::sq_stage_t  in,
  output mtq_pkg::sq_stage_t  out
);
  import mtq_pkg::*;

  sq_stage_t st      [SQRT_STEPS];
  sq_stage_t st_next [SQRT_STEPS];
  sq_stage_t src     [SQRT_STEPS];

  logic [RAD_W-1:0] rad;
  logic [1:0]       pair;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  always_comb begin
    src[0] = in;
    for (int j = 1; j < SQRT_STEPS; j++) begin
      src[j] = st[j-1];
    end
    for (int j = 0; j < SQRT_STEPS; j++) begin
      rad    = RAD_W'({src[j].arg, RAD_SHIFT'(0)});
      pair   = rad[2*(SQRT_STEPS-1-j) +: 2];
      rem_sh = {src[j].rem[REM_W-3:0], pair};
      trial  = REM_W'({src[j].root, 2'b01});
      st_next[j] = src[j];
      if (rem_sh >= trial) begin
        st_next[j].rem  = rem_sh - trial;
        st_next[j].root = {src[j].root[ROOT_W-2:0], 1'b1};
      end else begin
        st_next[j].rem  = rem_sh;
        st_next[j].root = {src[j].root[ROOT_W-2:0], 1'b0};
      end
      if (rst) begin
        st_next[j].valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < SQRT_STEPS; j++) begin
      st[j] <= st_next[j];
    end
  end

  assign out = st[SQRT_STEPS-1];

endmodule

### rtl/mtq_div.sv
// ---------------------------------------------------------------------------
// mtq_div: pipelined rounded fixed-point divider
// Gives round(|n| * 2^14 / s) as magnitude and sign, one quotient bit a stage.
// ---------------------------------------------------------------------------
module mtq_div (
  input  logic                                clk,
  input  logic signed [mtq_pkg::NUM_W-1:0]    n,
  input  logic [mtq_pkg::ROOT_W-1:0]          s,
  output logic [mtq_pkg::DIV_Q_W-1:0]         q,
  output logic                                neg
);
  import mtq_pkg::*;

  typedef struct packed {
    logic              neg;
    logic [DIVD_W-1:0] dvd;
    logic [ROOT_W-1:0] dvs;
    logic [ROOT_W-1:0] rem;
    logic [DIV_Q_W-1:0] quo;
  } dv_stage_t;

  dv_stage_t st      [DIV_LAT];
  dv_stage_t st_next [DIV_LAT];

  logic [NUM_W-1:0] mag;
  logic [ROOT_W:0]  rem_sh;

  always_comb begin
    mag = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
    // The divisor is at least 256 here, so the top dividend byte is below it.
    st_next[0].neg = n[NUM_W-1];
    st_next[0].dvd = DIVD_W'({mag, FRAC_BITS'(0)}) + DIVD_W'(s >> 1);
    st_next[0].dvs = s;
    st_next[0].rem = '0;
    st_next[0].quo = '0;
    for (int j = 1; j < DIV_LAT; j++) begin
      st_next[j] = st[j-1];
      if (j == 1) begin
        rem_sh = {ROOT_W'(st[0].dvd[DIVD_W-1:DIV_Q_W]), st[0].dvd[DIV_Q_W-1]};
      end else begin
        rem_sh = {st[j-1].rem, st[j-1].dvd[DIV_Q_W-j]};
      end
      if (rem_sh >= {1'b0, st[j-1].dvs}) begin
        st_next[j].rem = ROOT_W'(rem_sh - {1'b0, st[j-1].dvs});
        st_next[j].quo = {st[j-1].quo[DIV_Q_W-2:0], 1'b1};
      end else begin
        st_next[j].rem = rem_sh[ROOT_W-1:0];
        st_next[j].quo = {st[j-1].quo[DIV_Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_LAT; j++) begin
      st[j] <= st_next[j];
    end
  end

  assign q   = st[DIV_LAT-1].quo;
  assign neg = st[DIV_LAT-1].neg;

endmodule

### rtl/matrix_to_quaternion_top.sv
// ---------------------------------------------------------------------------
// matrix_to_quaternion_top: rotation matrix to unit quaternion
// Fully pipelined conversion of a Q2.14 3x3 matrix into qx, qy, qz, qw.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction is accepted on each rising edge with start high; busy is
//   always low, so a new matrix may be presented in every cycle.
//   Each result appears on qx, qy, qz, qw and invalid for exactly one cycle
//   with done high, in the order the matrices were accepted.
//   The pipeline has 2 setup stages, 17 square-root stages (one root
//   bit each), 25 divider stages (setup plus one quotient bit each) and the
//   output register. Throughput is one matrix per cycle.
//   The three divisions run in parallel dividers sharing the same root.
//   invalid is high, with all components zero, when the radicand is not
//   positive. Components saturate to the signed 16-bit range.
//   Synchronous reset clears all valid bits; transactions in flight are
//   dropped. The receiver cannot stall, so nothing ever waits inside.
// ---------------------------------------------------------------------------
module matrix_to_quaternion_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  mtq_pkg::word_t m00,
  input  mtq_pkg::word_t m01,
  input  mtq_pkg::word_t m02,
  input  mtq_pkg::word_t m10,
  input  mtq_pkg::word_t m11,
  input  mtq_pkg::word_t m12,
  input  mtq_pkg::word_t m20,
  input  mtq_pkg::word_t m21,
  input  mtq_pkg::word_t m22,
  output logic           done,
  output mtq_pkg::word_t qx,
  output mtq_pkg::word_t qy,
  output mtq_pkg::word_t qz,
  output mtq_pkg::word_t qw,
  output logic           invalid
);
  import mtq_pkg::*;

  matrix_t   mat;
  sq_stage_t front_out;
  sq_stage_t root_out;

  assign busy = 1'b0;
  assign mat  = '{m00: m00, m01: m01, m02: m02,
                  m10: m10, m11: m11, m12: m12,
                  m20: m20, m21: m21, m22: m22};

  mtq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .m        (mat),
    .out      (front_out)
  );

  mtq_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .in  (front_out),
    .out (root_out)
  );

  logic [DIV_Q_W-1:0] q0, q1, q2;
  logic               neg0, neg1, neg2;

  mtq_div u_div0 (.clk(clk), .n(root_out.meta.n0), .s(root_out.root), .q(q0), .neg(neg0));
  mtq_div u_div1 (.clk(clk), .n(root_out.meta.n1), .s(root_out.root), .q(q1), .neg(neg1));
  mtq_div u_div2 (.clk(clk), .n(root_out.meta.n2), .s(root_out.root), .q(q2), .neg(neg2));

  // Side data travels next to the dividers.
  out_meta_t dly      [DIV_LAT];
  out_meta_t dly_next [DIV_LAT];

  always_comb begin
    dly_next[0].valid   = root_out.valid && !rst;
    dly_next[0].invalid = root_out.meta.invalid;
    dly_next[0].slot    = root_out.meta.slot;
    dly_next[0].quarter = QRT_W'((ROOT_W+1)'(root_out.root) + (ROOT_W+1)'(2) >> 2);
    for (int j = 1; j < DIV_LAT; j++) begin
      dly_next[j] = dly[j-1];
      if (rst) begin
        dly_next[j].valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_LAT; j++) begin
      dly[j] <= dly_next[j];
    end
  end

  out_meta_t                tail;
  logic signed [DIV_Q_W:0]  v0, v1, v2;
  word_t                    w0, w1, w2, wq;
  word_t                    qx_next, qy_next, qz_next, qw_next;

  always_comb begin
    tail = dly[DIV_LAT-1];
    v0 = neg0 ? -$signed({1'b0, q0}) : $signed({1'b0, q0});
    v1 = neg1 ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
    v2 = neg2 ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
    w0 = sat_word(v0);
    w1 = sat_word(v1);
    w2 = sat_word(v2);
    wq = sat_word($signed((DIV_Q_W+1)'(tail.quarter)));
    case (tail.slot)
      SLOT_X: begin
        qx_next = wq; qy_next = w0; qz_next = w1; qw_next = w2;
      end
      SLOT_Y: begin
        qx_next = w0; qy_next = wq; qz_next = w1; qw_next = w2;
      end
      SLOT_Z: begin
        qx_next = w0; qy_next = w1; qz_next = wq; qw_next = w2;
      end
      default: begin
        qx_next = w0; qy_next = w1; qz_next = w2; qw_next = wq;
      end
    endcase
    if (tail.invalid) begin
      qx_next = '0;
      qy_next = '0;
      qz_next = '0;
      qw_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tail.valid;
    end
    qx      <= qx_next;
    qy      <= qy_next;
    qz      <= qz_next;
    qw      <= qw_next;
    invalid <= tail.invalid;
  end

endmodule

### test/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for matrix_to_quaternion_top
// Drives Q2.14 matrices through the start/busy handshake with random gaps,
// predicts each quaternion with an integer model of the conversion and
// compares every done strobe against the oldest prediction.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtq_pkg::*;

  typedef struct {
    word_t m [9];
  } mat_in_t;

  typedef struct {
    word_t  x, y, z, w;
    logic   bad;
  } quat_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  word_t m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0, m12 = '0;
  word_t m20 = '0, m21 = '0, m22 = '0;
  logic  done;
  word_t qx, qy, qz, qw;
  logic  invalid;

  mat_in_t pending_mats[$];
  quat_t   expected_quats[$];
  int      errors = 0;
  int      gap = 0;
  bit      stim_done = 0;

  matrix_to_quaternion_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .done(done), .qx(qx), .qy(qy), .qz(qz), .qw(qw), .invalid(invalid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // floor(sqrt(v)) by bit-wise search
  function automatic longint isqrt(input longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v) begin
        r = r + (longint'(1) << b);
      end
    end
    return r;
  endfunction

  function automatic longint round_div(input longint n, input longint s);
    longint mag, q;
    mag = (n < 0) ? -n : n;
    q = ((mag << FRAC_BITS) + s / 2) / s;
    if (q > (longint'(1) << 40)) begin
      q = longint'(1) << 40;
    end
    return (n < 0) ? -q : q;
  endfunction

  function automatic word_t clamp16(input longint v);
    if (v > 32767) begin
      return 16'sd32767;
    end
    if (v < -32768) begin
      return -16'sd32768;
    end
    return word_t'(v);
  endfunction

  function automatic quat_t convert_matrix(input mat_in_t a);
    longint m [9];
    longint rad, s, vx, vy, vz, vw;
    int     k;
    quat_t  q;
    for (int i = 0; i < 9; i++) begin
      m[i] = a.m[i];
    end
    q.bad = 1'b0;
    if (m[0] + m[4] + m[8] > 0) begin
      rad = 16384 + m[0] + m[4] + m[8];
      // 2*sqrt(arg) in Q14 is sqrt(arg * 2^16).
      s = isqrt(rad << 16);
      vx = round_div(m[5] - m[7], s);
      vy = round_div(m[6] - m[2], s);
      vz = round_div(m[1] - m[3], s);
      vw = (s + 2) >>> 2;
    end else begin
      k = 0;
      if (m[4] > m[0]) k = 1;
      if (m[8] > m[k * 4]) k = 2;
      if (k == 0) rad = 16384 + m[0] - m[4] - m[8];
      else if (k == 1) rad = 16384 + m[4] - m[0] - m[8];
      else rad = 16384 + m[8] - m[0] - m[4];
      if (rad <= 0) begin
        q.x = '0; q.y = '0; q.z = '0; q.w = '0; q.bad = 1'b1;
        return q;
      end
      s = isqrt(rad << 16);
      if (k == 0) begin
        vx = (s + 2) >>> 2;
        vy = round_div(m[1] + m[3], s);
        vz = round_div(m[2] + m[6], s);
        vw = round_div(m[5] - m[7], s);
      end else if (k == 1) begin
        vx = round_div(m[1] + m[3], s);
        vy = (s + 2) >>> 2;
        vz = round_div(m[5] + m[7], s);
        vw = round_div(m[6] - m[2], s);
      end else begin
        vx = round_div(m[2] + m[6], s);
        vy = round_div(m[5] + m[7], s);
        vz = (s + 2) >>> 2;
        vw = round_div(m[1] - m[3], s);
      end
    end
    q.x = clamp16(vx); q.y = clamp16(vy); q.z = clamp16(vz); q.w = clamp16(vw);
    return q;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  task automatic push_mat(input int a0, a1, a2, a3, a4, a5, a6, a7, a8);
    mat_in_t t;
    t.m[0] = word_t'(a0); t.m[1] = word_t'(a1); t.m[2] = word_t'(a2);
    t.m[3] = word_t'(a3); t.m[4] = word_t'(a4); t.m[5] = word_t'(a5);
    t.m[6] = word_t'(a6); t.m[7] = word_t'(a7); t.m[8] = word_t'(a8);
    pending_mats.push_back(t);
  endtask

  function automatic word_t near_value(input int c);
    return word_t'(c + $signed($urandom_range(0, 4000)) - 2000);
  endfunction

  initial begin
    mat_in_t t;
    int      c, r;
    // Identity and the three half-turns select each branch of the formula.
    push_mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
    push_mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
    push_mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);
    push_mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
    push_mat(0, -16384, 0, 16384, 0, 0, 0, 0, 1);
    // Ties on the diagonal go to the lower index.
    push_mat(-100, 5, 6, 7, -100, 8, 9, 10, -100);
    push_mat(-200, 5, 6, 7, -100, 8, 9, 10, -100);
    // Non-positive trace; the selected radicand is still positive.
    push_mat(-16384, 1, 2, 3, -16384, 4, 5, 6, -16384);
    push_mat(-8192, 1, 2, 3, 0, 4, 5, 6, 8192);
    push_mat(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    // Extreme values; one of them drives a component into saturation.
    push_mat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    push_mat(1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0);
    push_mat(0, 32767, 32767, -32768, 0, 32767, -32768, -32768, 0);
    push_mat(-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, 32767);
    push_mat(32767, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    push_mat(0, 0, 0, 0, 0, 0, 0, 0, 0);
    push_mat(1, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int n = 0; n < 1250; n++) begin
      r = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
        if (r < 3) begin
          t.m[i] = word_t'($urandom());
        end else begin
          // Values near random centres, drawn alike on and off the diagonal, pick varied branches.
          c = (i % 4 == 0) ? $signed($urandom_range(0, 32768)) - 16384
                           : $signed($urandom_range(0, 32768)) - 16384;
          t.m[i] = near_value(c);
        end
      end
      pending_mats.push_back(t);
    end
    stim_done = 1;
  end

  // Driver: start is held across back-to-back items without dropping.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_quats.push_back(convert_matrix('{m: '{m00, m01, m02, m10, m11,
                                                      m12, m20, m21, m22}}));
      void'(pending_mats.pop_front());
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap == 0 && pending_mats.size() > 0) begin
        {m00, m01, m02} <= {pending_mats[0].m[0], pending_mats[0].m[1],
                            pending_mats[0].m[2]};
        {m10, m11, m12} <= {pending_mats[0].m[3], pending_mats[0].m[4],
                            pending_mats[0].m[5]};
        {m20, m21, m22} <= {pending_mats[0].m[6], pending_mats[0].m[7],
                            pending_mats[0].m[8]};
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_mats.size() > 0) begin
      if (gap > 0) begin
        gap--;
      end else begin
        start <= 1'b1;
        {m00, m01, m02} <= {pending_mats[0].m[0], pending_mats[0].m[1],
                            pending_mats[0].m[2]};
        {m10, m11, m12} <= {pending_mats[0].m[3], pending_mats[0].m[4],
                            pending_mats[0].m[5]};
        {m20, m21, m22} <= {pending_mats[0].m[6], pending_mats[0].m[7],
                            pending_mats[0].m[8]};
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    quat_t e;
    if (!rst && done) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        e = expected_quats.pop_front();
        if (qx !== e.x) report_mismatch("qx", qx, e.x);
        if (qy !== e.y) report_mismatch("qy", qy, e.y);
        if (qz !== e.z) report_mismatch("qz", qz, e.z);
        if (qw !== e.w) report_mismatch("qw", qw, e.w);
        if (invalid !== e.bad) report_mismatch("invalid", invalid, e.bad);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    while (pending_mats.size() > 0 || start) @(posedge clk);
    while (expected_quats.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

### sim.f
rtl/mtq_pkg.sv
rtl/mtq_front.sv
rtl/mtq_sqrt.sv
rtl/mtq_div.sv
rtl/matrix_to_quaternion_top.sv
test/tb.sv
